@@ src/dfs_pkg.sv @@
// Package of the delimiter field splitter: sizes, register indexes,
// configuration and result types. No dependencies.
`default_nettype none
package dfs_pkg;

  localparam int unsigned MAX_STRING_LEN = 4096;
  localparam int unsigned MAP_BITS       = 256;
  localparam int unsigned POS_W          = 12;
  localparam int unsigned CNT_W          = 8;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 64;
  localparam int unsigned POS_MAX_INT    =
    (MAX_STRING_LEN - 1 < 4095) ? (MAX_STRING_LEN - 1) : 4095;
  localparam logic [POS_W-1:0] POS_MAX   = POS_W'(POS_MAX_INT);

  localparam logic [CFG_IDX_W-1:0] CFG_SEP_MAP_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_MAP_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_MAP_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_MAP_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FIELDS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COLLAPSE   = 3'd5;

  localparam logic [CFG_DATA_W-1:0] SEP_MAP_0_RST = 64'h0000_0001_0000_0200;
  localparam logic [CNT_W-1:0]      MAX_FIELDS_RST = 8'd255;

  typedef struct packed {
    logic [MAP_BITS-1:0] sep_map;
    logic [CNT_W-1:0]    max_fields;
    logic                collapse_runs;
  } dfs_cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] field_start;
    logic [POS_W-1:0] field_length;
    logic [CNT_W-1:0] field_number;
    logic             has_field;
    logic             end_of_string;
    logic             too_long;
  } dfs_result_t;

endpackage
`default_nettype wire

@@ src/dfs_if.sv @@
// Channel interfaces of the delimiter field splitter: string bytes in,
// field results out and configuration writes. Depends on dfs_pkg.
`default_nettype none
interface dfs_byte_if import dfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] string_byte;
  modport source (output valid, output string_byte, input ready);
  modport sink   (input valid, input string_byte, output ready);
endinterface

interface dfs_field_if import dfs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] field_start;
  logic [POS_W-1:0] field_length;
  logic [CNT_W-1:0] field_number;
  logic             has_field;
  logic             end_of_string;
  logic             too_long;
  modport source (output valid, output field_start, output field_length,
                  output field_number, output has_field, output end_of_string,
                  output too_long, input ready);
  modport sink   (input valid, input field_start, input field_length,
                  input field_number, input has_field, input end_of_string,
                  input too_long, output ready);
endinterface

interface dfs_cfg_if import dfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ src/dfs_cfg_regs.sv @@
// Configuration register file of the delimiter field splitter.
// Depends on dfs_pkg and dfs_cfg_if.
`default_nettype none
module dfs_cfg_regs import dfs_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  dfs_cfg_if.sink     cfg_i,
  output dfs_cfg_t    cfg_o
);

  logic [CFG_DATA_W-1:0] map0_q, map1_q, map2_q, map3_q;
  logic [CNT_W-1:0]      max_fields_q;
  logic                  collapse_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map0_q       <= SEP_MAP_0_RST;
      map1_q       <= '0;
      map2_q       <= '0;
      map3_q       <= '0;
      max_fields_q <= MAX_FIELDS_RST;
      collapse_q   <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SEP_MAP_0:  map0_q       <= cfg_i.data;
        CFG_SEP_MAP_1:  map1_q       <= cfg_i.data;
        CFG_SEP_MAP_2:  map2_q       <= cfg_i.data;
        CFG_SEP_MAP_3:  map3_q       <= cfg_i.data;
        CFG_MAX_FIELDS: max_fields_q <= cfg_i.data[CNT_W-1:0];
        CFG_COLLAPSE:   collapse_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign cfg_o.sep_map       = {map3_q, map2_q, map1_q, map0_q};
  assign cfg_o.max_fields    = max_fields_q;
  assign cfg_o.collapse_runs = collapse_q;

endmodule
`default_nettype wire

@@ src/dfs_core.sv @@
// Per-string state and field decision of the delimiter field splitter.
// Depends on dfs_pkg.
`default_nettype none
module dfs_core import dfs_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               step_i,
  input  wire  [BYTE_W-1:0] byte_i,
  input  dfs_cfg_t          cfg_i,
  output logic              emit_o,
  output dfs_result_t       result_o
);

  logic [POS_W-1:0] pos_q, pos_d, start_q, start_d;
  logic [CNT_W-1:0] fo_q, fo_d;
  logic             inside_q, inside_d, limit_q, limit_d, ovf_q, ovf_d;

  logic             is_end, is_sep, open, close;
  logic [POS_W-1:0] start_n;
  logic [CNT_W-1:0] fo_n, fo_inc;
  logic             inside_n, limit_n;

  always_comb begin
    is_end   = (byte_i == '0);
    is_sep   = !is_end && cfg_i.sep_map[byte_i];
    fo_inc   = fo_q + 1'b1;
    open     = (!cfg_i.collapse_runs || (!is_end && !is_sep)) && !inside_q &&
               (fo_q < cfg_i.max_fields);
    start_n  = open ? pos_q : start_q;
    fo_n     = open ? fo_inc : fo_q;
    inside_n = inside_q || open;
    limit_n  = limit_q || (open && (fo_inc >= cfg_i.max_fields));
    close    = is_sep && inside_n && !limit_n;

    emit_o                 = is_end || close;
    result_o.has_field     = is_end ? inside_n : 1'b1;
    result_o.field_start   = result_o.has_field ? start_n : '0;
    result_o.field_length  = result_o.has_field ? (pos_q - start_n) : '0;
    result_o.field_number  = fo_n;
    result_o.end_of_string = is_end;
    result_o.too_long      = ovf_q;

    if (is_end) begin
      pos_d    = '0;
      start_d  = '0;
      fo_d     = '0;
      inside_d = 1'b0;
      limit_d  = 1'b0;
      ovf_d    = 1'b0;
    end else begin
      start_d  = start_n;
      fo_d     = fo_n;
      inside_d = inside_n && !close;
      limit_d  = limit_n;
      if (pos_q < POS_MAX) begin
        pos_d = pos_q + 1'b1;
        ovf_d = ovf_q;
      end else begin
        pos_d = pos_q;
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      start_q  <= '0;
      fo_q     <= '0;
      inside_q <= 1'b0;
      limit_q  <= 1'b0;
      ovf_q    <= 1'b0;
    end else if (step_i) begin
      pos_q    <= pos_d;
      start_q  <= start_d;
      fo_q     <= fo_d;
      inside_q <= inside_d;
      limit_q  <= limit_d;
      ovf_q    <= ovf_d;
    end
  end

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && is_end |=> pos_q == '0 && fo_q == '0 && !inside_q && !ovf_q)
    else $error("string state not cleared after terminator");
  a_open_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inside_q |-> fo_q != '0)
    else $error("open field without a field count");
  a_start_le_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q <= pos_q)
    else $error("field start beyond current offset");
  a_ovf_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> pos_q == POS_MAX)
    else $error("overflow flag set before offset saturated");
`endif

endmodule
`default_nettype wire

@@ src/delimiter_field_splitter.sv @@
// Delimiter field splitter: splits zero-terminated byte strings into fields.
// One byte is transferred per cycle on byte_i while ready is high. A byte
// flagged in the 256-bit separator map (configuration registers 0 to 3)
// separates fields; configuration register 4 bounds the field count and
// register 5 selects collapse of separator runs. Writes on cfg_i are always
// taken. Each closed field, and every terminating zero byte, gives one
// transfer on field_o with offset, length and field count.
// A result is registered after its byte has passed the input register.
// Throughput is one byte per cycle: the byte sits in an input register while
// the per-string counters and the map lookup decide, and a result register
// holds the outcome. When field_o stalls, a byte that gives no result still
// moves on, and a byte that gives a result waits in the input register,
// which then drops ready. Reset restores the configuration reset values,
// clears the per-string state and empties both registers.
// Depends on dfs_pkg, the dfs interfaces, dfs_cfg_regs and dfs_core.
`default_nettype none
module delimiter_field_splitter import dfs_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  dfs_byte_if.sink    byte_i,
  dfs_field_if.source field_o,
  dfs_cfg_if.sink     cfg_i
);

  dfs_cfg_t          cfg;
  logic              in_vld_q;
  logic [BYTE_W-1:0] byte_q;
  logic              out_vld_q;
  dfs_result_t       res_q;
  logic              emit, advance;
  dfs_result_t       result;

  dfs_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  dfs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (byte_q),
    .cfg_i    (cfg),
    .emit_o   (emit),
    .result_o (result)
  );

  assign advance      = in_vld_q && (!emit || !out_vld_q || field_o.ready);
  assign byte_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (byte_i.ready) begin
        in_vld_q <= byte_i.valid;
      end
      if (advance && emit) begin
        out_vld_q <= 1'b1;
      end else if (field_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      byte_q <= byte_i.string_byte;
    end
    if (advance && emit) begin
      res_q <= result;
    end
  end

  assign field_o.valid         = out_vld_q;
  assign field_o.field_start   = res_q.field_start;
  assign field_o.field_length  = res_q.field_length;
  assign field_o.field_number  = res_q.field_number;
  assign field_o.has_field     = res_q.has_field;
  assign field_o.end_of_string = res_q.end_of_string;
  assign field_o.too_long      = res_q.too_long;

endmodule
`default_nettype wire

@@ bench/dfs_field_checker.sv @@
// Scoreboard for the delimiter field splitter: watches the byte, field and
// configuration channels, predicts every field result and compares it.
// Depends on dfs_pkg and the dfs channel interfaces.
module dfs_field_checker import dfs_pkg::*; #(
  parameter logic [BYTE_W-1:0] TERMINATOR = '0
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  dfs_byte_if  byte_mon,
  dfs_field_if field_mon,
  dfs_cfg_if   cfg_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 20;

  logic [MAP_BITS-1:0] sep_map;
  logic [CNT_W-1:0]    max_fields;
  logic                collapse;

  logic [POS_W-1:0] cur_pos;
  logic [POS_W-1:0] field_begin;
  logic [CNT_W-1:0] opened;
  logic             in_field;
  logic             at_limit;
  logic             saturated;

  dfs_result_t pending_fields[$];
  int          fails;
  int          checked;

  task automatic clear_string();
    cur_pos     = '0;
    field_begin = '0;
    opened      = '0;
    in_field    = 1'b0;
    at_limit    = 1'b0;
    saturated   = 1'b0;
  endtask

  function automatic dfs_result_t field_result(input logic with_field, input logic at_end);
    dfs_result_t r;
    r = '0;
    if (with_field) begin
      r.field_start  = field_begin;
      r.field_length = (cur_pos >= field_begin) ? cur_pos - field_begin : '0;
    end
    r.field_number  = opened;
    r.has_field     = with_field;
    r.end_of_string = at_end;
    r.too_long      = saturated;
    return r;
  endfunction

  task automatic predict_split(input logic [BYTE_W-1:0] b);
    logic is_sep;
    is_sep = (b != TERMINATOR) && sep_map[b];
    if (!collapse || (b != TERMINATOR && !is_sep)) begin
      if (!in_field && opened < max_fields) begin
        in_field    = 1'b1;
        field_begin = cur_pos;
        opened      = opened + 1'b1;
        if (opened >= max_fields) at_limit = 1'b1;
      end
    end
    if (b == TERMINATOR) begin
      pending_fields.push_back(field_result(in_field, 1'b1));
      clear_string();
    end else begin
      if (is_sep && in_field && !at_limit) begin
        pending_fields.push_back(field_result(1'b1, 1'b0));
        in_field = 1'b0;
      end
      if (cur_pos < POS_MAX) cur_pos = cur_pos + 1'b1;
      else saturated = 1'b1;
    end
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_SEP_MAP_0:  sep_map[63:0]    = val;
      CFG_SEP_MAP_1:  sep_map[127:64]  = val;
      CFG_SEP_MAP_2:  sep_map[191:128] = val;
      CFG_SEP_MAP_3:  sep_map[255:192] = val;
      CFG_MAX_FIELDS: max_fields       = val[CNT_W-1:0];
      CFG_COLLAPSE:   collapse         = val[0];
      default: ;
    endcase
  endtask

  task automatic check_result();
    dfs_result_t got;
    dfs_result_t want;
    got.field_start   = field_mon.field_start;
    got.field_length  = field_mon.field_length;
    got.field_number  = field_mon.field_number;
    got.has_field     = field_mon.has_field;
    got.end_of_string = field_mon.end_of_string;
    got.too_long      = field_mon.too_long;
    if (pending_fields.size() == 0) begin
      fails++;
      if (fails <= MAX_REPORTS)
        $display("%0t: unexpected result start=%0d len=%0d num=%0d has=%0b end=%0b long=%0b",
                 $time, got.field_start, got.field_length, got.field_number,
                 got.has_field, got.end_of_string, got.too_long);
    end else begin
      want = pending_fields.pop_front();
      checked++;
      if (got.field_start !== want.field_start || got.field_length !== want.field_length ||
          got.field_number !== want.field_number || got.has_field !== want.has_field ||
          got.end_of_string !== want.end_of_string || got.too_long !== want.too_long) begin
        fails++;
        if (fails <= MAX_REPORTS) begin
          $display("%0t: mismatch, expected start=%0d len=%0d num=%0d has=%0b end=%0b long=%0b",
                   $time, want.field_start, want.field_length, want.field_number,
                   want.has_field, want.end_of_string, want.too_long);
          $display("%0t:           actual start=%0d len=%0d num=%0d has=%0b end=%0b long=%0b",
                   $time, got.field_start, got.field_length, got.field_number,
                   got.has_field, got.end_of_string, got.too_long);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_map    = {{(MAP_BITS-CFG_DATA_W){1'b0}}, SEP_MAP_0_RST};
      max_fields = MAX_FIELDS_RST;
      collapse   = 1'b0;
      clear_string();
      pending_fields.delete();
      fails   = 0;
      checked = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) apply_write(cfg_mon.index, cfg_mon.data);
      if (field_mon.valid && field_mon.ready) check_result();
      if (byte_mon.valid && byte_mon.ready) predict_split(byte_mon.string_byte);
      fail_count_o <= fails;
      pending_o    <= pending_fields.size();
      checked_o    <= checked;
    end
  end

endmodule

@@ bench/tb_top.sv @@
// Top of the delimiter field splitter bench: clock, reset, string and
// configuration stimulus, random idling on both sides, and the verdict.
// Depends on dfs_pkg, the dfs interfaces, the splitter and dfs_field_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dfs_pkg::*;

  localparam logic [BYTE_W-1:0]    END_BYTE    = '0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_COLLAPSE + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_COLLAPSE + 3'd2;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 8;
  localparam int PHASE_BYTES  = 150;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int send_idle_pct;
  int stall_pct;
  int bytes_sent;
  int strings_sent;
  int settings;
  int cycles = 0;
  int fail_count;
  int pending;
  int checked;
  logic [MAP_BITS-1:0] sep_shadow;

  dfs_byte_if  byte_ch ();
  dfs_field_if field_ch ();
  dfs_cfg_if   cfg_ch ();

  delimiter_field_splitter dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .byte_i  (byte_ch),
    .field_o (field_ch),
    .cfg_i   (cfg_ch)
  );

  dfs_field_checker #(.TERMINATOR(END_BYTE)) field_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .byte_mon     (byte_ch),
    .field_mon    (field_ch),
    .cfg_mon      (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycles, pending);
      $display("FAIL delimiter_field_splitter");
      $finish;
    end
  end

  always @(negedge clk) begin
    field_ch.ready = ($urandom_range(99) >= stall_pct);
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid = 1'b0;
      @(negedge clk);
    end
    byte_ch.valid       = 1'b1;
    byte_ch.string_byte = b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    byte_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    if (idx <= CFG_SEP_MAP_3) sep_shadow[idx*CFG_DATA_W +: CFG_DATA_W] = val;
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] m0, input logic [CFG_DATA_W-1:0] m1,
                            input logic [CFG_DATA_W-1:0] m2, input logic [CFG_DATA_W-1:0] m3,
                            input logic [CNT_W-1:0] maxf, input logic coll);
    write_reg(CFG_SEP_MAP_0, m0);
    write_reg(CFG_SEP_MAP_1, m1);
    write_reg(CFG_SEP_MAP_2, m2);
    write_reg(CFG_SEP_MAP_3, m3);
    write_reg(CFG_MAX_FIELDS, CFG_DATA_W'(maxf));
    write_reg(CFG_COLLAPSE, CFG_DATA_W'(coll));
    settings++;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte(input int sep_pct);
    logic [BYTE_W-1:0] b;
    logic want_sep;
    want_sep = ($urandom_range(99) < sep_pct);
    b = BYTE_W'($urandom_range(1, 255));
    for (int t = 0; t < 32 && sep_shadow[b] != want_sep; t++)
      b = BYTE_W'($urandom_range(1, 255));
    return b;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_map_word(input logic keep_blanks);
    logic [CFG_DATA_W-1:0] w;
    case ($urandom_range(0, 5))
      0: w = '0;
      1: w = '1;
      5: w = {$urandom, $urandom};
      default: begin
        w = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        if (keep_blanks) w = w | SEP_MAP_0_RST;
      end
    endcase
    return w;
  endfunction

  function automatic logic [CNT_W-1:0] rand_max_fields();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CNT_W'(1);
      2: return CNT_W'(2);
      3: return CNT_W'(3);
      4: return CNT_W'($urandom_range(4, 254));
      default: return '1;
    endcase
  endfunction

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_byte(text[i]);
    send_byte(END_BYTE);
    strings_sent++;
  endtask

  task automatic send_random_string(input int len, input int sep_pct);
    for (int i = 0; i < len; i++) send_byte(pick_byte(sep_pct));
    send_byte(END_BYTE);
    strings_sent++;
  endtask

  // Separators are dense near the length bound so fields close after saturation.
  task automatic send_long_string(input int len);
    for (int i = 0; i < len; i++) send_byte(pick_byte((i >= POS_MAX_INT - 8) ? 40 : 1));
    send_byte(END_BYTE);
    strings_sent++;
  endtask

  initial begin
    int phase_start;
    int len;
    logic paused;
    byte_ch.valid       = 1'b0;
    byte_ch.string_byte = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_SEP_MAP_0;
    cfg_ch.data         = '0;
    field_ch.ready      = 1'b0;
    send_idle_pct       = 0;
    stall_pct           = 0;
    bytes_sent          = 0;
    strings_sent        = 0;
    settings            = 1;
    paused              = 1'b0;
    sep_shadow          = {{(MAP_BITS-CFG_DATA_W){1'b0}}, SEP_MAP_0_RST};
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Plain mode from reset: empty string, empty inner and trailing fields.
    send_text("");
    send_text("a \t");
    settle();
    write_reg(CFG_COLLAPSE, CFG_DATA_W'(1));
    send_text(" a  b ");
    send_text("");
    settle();
    write_reg(CFG_COLLAPSE, '0);
    write_reg(CFG_MAX_FIELDS, '0);
    send_text("a");
    settle();
    write_reg(CFG_MAX_FIELDS, CFG_DATA_W'(2));
    write_reg(CFG_COLLAPSE, CFG_DATA_W'(1));
    send_text("a b c");
    settle();
    set_config('1, '1, '1, '1, '1, 1'b0);
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, '0);
    send_text("\001\377");
    settle();

    // A field limit lowered in the middle of a string.
    set_config(SEP_MAP_0_RST, '0, '0, '0, '1, 1'b0);
    send_byte("a");
    send_byte(" ");
    send_byte("b");
    settle();
    write_reg(CFG_MAX_FIELDS, CFG_DATA_W'(1));
    send_text(" c");
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 49; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      set_config(rand_map_word(1'b1), rand_map_word(1'b0), rand_map_word(1'b0),
                 rand_map_word(1'b0), rand_max_fields(), 1'($urandom_range(0, 1)));
      if (p == 2) begin
        send_long_string(POS_MAX_INT);
        send_long_string(POS_MAX_INT + 1);
      end
      if (p == 6) send_long_string($urandom_range(POS_MAX_INT + 2, POS_MAX_INT + 120));
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        send_random_string(len, $urandom_range(5, 60));
        if (p == 3 && !paused && bytes_sent - phase_start > 60) begin
          settle();
          paused = 1'b1;
        end
      end
      settle();
    end

    $display("Run covered %0d bytes in %0d strings under %0d register settings,",
             bytes_sent, strings_sent, settings);
    $display("with %0d field results compared and %0d failures.", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS delimiter_field_splitter");
    end else begin
      $display("FAIL delimiter_field_splitter");
    end
    $finish;
  end

endmodule

@@ delimiter_field_splitter.f @@
src/dfs_pkg.sv
src/dfs_if.sv
src/dfs_cfg_regs.sv
src/dfs_core.sv
src/delimiter_field_splitter.sv
bench/dfs_field_checker.sv
bench/tb_top.sv
